FILE: src/ssm_pkg.sv
// Shared types, widths and codes for the sorted stream key merge.
`default_nettype none
package ssm_pkg;

    localparam int NUM_SERIES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_OUT         = 4;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int FID_W = 2;
    localparam int SER_W = 2;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_NEXT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_PUSH_OK   = 2'd0,
        ST_PUSH_FULL = 2'd1,
        ST_MERGED    = 2'd2,
        ST_NONE      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_NONE,
        S_RD,
        S_CMP
    } t_state;

endpackage
`default_nettype wire

FILE: src/ssm_store.sv
// Key and value/fidelity sample memories, one write and one registered read port.
`default_nettype none
module ssm_store
    import ssm_pkg::*;
#(
    parameter int DEPTH = NUM_SERIES_DEF * QUEUE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [KEY_W-1:0]         i_wkey,
    input  wire logic [VAL_W+FID_W-1:0]   i_wval,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [KEY_W-1:0]         o_rkey,
    output logic      [VAL_W+FID_W-1:0]   o_rval
);

    logic [KEY_W-1:0]       key_mem [DEPTH];
    logic [VAL_W+FID_W-1:0] val_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            key_mem[i_waddr] <= i_wkey;
            val_mem[i_waddr] <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rkey <= key_mem[i_raddr];
            o_rval <= val_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/sorted_stream_key_merge.sv
// Sequence: a push is accepted, then written and answered in S_PUSH once the output
// register is free; a next command scans the heads in S_SCAN, S_SCAN_END and S_DECIDE,
// then visits each non-empty series in the pop pass with S_RD and S_CMP (one read port).
// Flow control: one transaction in flight, taken only when the sequencer is idle,
// even while a result waits in the output reg.
// Reset: synchronous active low clears pointers, fill counts, sequencer and output valid.
`default_nettype none
module sorted_stream_key_merge
    import ssm_pkg::*;
#(
    parameter int NUM_SERIES  = NUM_SERIES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_command,
    input  wire logic [SER_W-1:0]        i_series,
    input  wire logic signed [KEY_W-1:0] i_sample_key,
    input  wire logic signed [VAL_W-1:0] i_sample_value,
    input  wire logic [FID_W-1:0]        i_sample_fidelity,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_status,
    output logic signed [KEY_W-1:0]      o_merged_key,
    output logic [SER_W-1:0]             o_source_series,
    output logic signed [VAL_W-1:0]      o_merged_value,
    output logic [FID_W-1:0]             o_merged_fidelity,
    output logic                         o_last
);

    localparam int DEPTH = NUM_SERIES * QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = $clog2(NUM_SERIES);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = $clog2(MAX_OUT + 1);
    localparam logic [AW-1:0] QD_A   = AW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] IDX_LAST = SW'(NUM_SERIES - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_OUT);

    t_state r_state, n_state;

    logic [PW-1:0] r_rptr [NUM_SERIES];
    logic [PW-1:0] n_rptr [NUM_SERIES];
    logic [PW-1:0] r_wptr [NUM_SERIES];
    logic [PW-1:0] n_wptr [NUM_SERIES];
    logic [FW-1:0] r_fill [NUM_SERIES];
    logic [FW-1:0] n_fill [NUM_SERIES];

    logic [SW-1:0] r_idx, n_idx;
    logic          r_p1_vld, n_p1_vld;
    logic          r_p1_occ, n_p1_occ;
    logic          r_found, n_found;
    logic signed [KEY_W-1:0] r_best, n_best;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_emit, n_emit;

    // accepted transaction
    logic [SER_W-1:0] r_series, n_series;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_val, n_val;
    logic [FID_W-1:0] r_fid, n_fid;

    // output register
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic signed [KEY_W-1:0] r_out_key, n_out_key;
    logic [SER_W-1:0]        r_out_series, n_out_series;
    logic signed [VAL_W-1:0] r_out_val, n_out_val;
    logic [FID_W-1:0]        r_out_fid, n_out_fid;
    logic                    r_out_last, n_out_last;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [KEY_W-1:0]       rd_key;
    logic [VAL_W+FID_W-1:0] rd_val;

    logic          out_free;
    logic          in_range;
    logic [SW-1:0] push_idx;
    logic          push_full;
    logic          pop_go;
    logic          pop_last;

    ssm_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wkey (r_key),
        .i_wval ({r_fid, r_val}),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rkey (rd_key),
        .o_rval (rd_val)
    );

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_range  = 32'(r_series) < NUM_SERIES;
    assign push_idx  = SW'(r_series);
    assign push_full = !in_range || (r_fill[push_idx] == FILL_FULL);
    assign mem_waddr = AW'(push_idx) * QD_A + AW'(r_wptr[push_idx]);
    assign mem_raddr = AW'(r_idx) * QD_A + AW'(r_rptr[r_idx]);
    assign pop_last  = (r_emit + CW'(1)) == r_cnt;
    assign pop_go    = (r_state == S_CMP) && (rd_key == r_best) && out_free;

    always_comb begin
        n_state      = r_state;
        n_rptr       = r_rptr;
        n_wptr       = r_wptr;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_p1_vld     = r_p1_vld;
        n_p1_occ     = r_p1_occ;
        n_found      = r_found;
        n_best       = r_best;
        n_cnt        = r_cnt;
        n_emit       = r_emit;
        n_series     = r_series;
        n_key        = r_key;
        n_val        = r_val;
        n_fid        = r_fid;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_key    = r_out_key;
        n_out_series = r_out_series;
        n_out_val    = r_out_val;
        n_out_fid    = r_out_fid;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        o_in_ready   = 1'b0;

        // head compare for the scan pass, in the cycle after the read
        if (r_p1_vld && r_p1_occ) begin
            if (!r_found || ($signed(rd_key) < r_best)) begin
                n_best  = $signed(rd_key);
                n_cnt   = CW'(1);
                n_found = 1'b1;
            end else if ($signed(rd_key) == r_best && r_cnt != CNT_MAX) begin
                n_cnt = r_cnt + CW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_series = i_series;
                    n_key    = i_sample_key;
                    n_val    = i_sample_value;
                    n_fid    = i_sample_fidelity;
                    n_idx    = '0;
                    n_p1_vld = 1'b0;
                    n_found  = 1'b0;
                    n_cnt    = '0;
                    n_emit   = '0;
                    n_state  = (t_cmd'(i_command) == CMD_PUSH) ? S_PUSH : S_SCAN;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = push_full ? ST_PUSH_FULL : ST_PUSH_OK;
                    n_out_key    = '0;
                    n_out_series = '0;
                    n_out_val    = '0;
                    n_out_fid    = '0;
                    n_out_last   = 1'b1;
                    if (!push_full) begin
                        mem_we = 1'b1;
                        n_wptr[push_idx] = (r_wptr[push_idx] == PTR_LAST) ? '0 :
                                           r_wptr[push_idx] + PW'(1);
                        n_fill[push_idx] = r_fill[push_idx] + FW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                mem_re   = 1'b1;
                n_p1_vld = 1'b1;
                n_p1_occ = r_fill[r_idx] != '0;
                if (r_idx == IDX_LAST) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_SCAN_END: begin
                n_p1_vld = 1'b0;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                n_idx   = '0;
                n_state = r_found ? S_RD : S_NONE;
            end
            S_NONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_NONE;
                    n_out_key    = '0;
                    n_out_series = '0;
                    n_out_val    = '0;
                    n_out_fid    = '0;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                if (r_fill[r_idx] != '0) begin
                    mem_re  = 1'b1;
                    n_state = S_CMP;
                end else if (r_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_CMP: begin
                if (rd_key != r_best || pop_go) begin
                    if (pop_go) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_MERGED;
                        n_out_key    = r_best;
                        n_out_series = SER_W'(r_idx);
                        n_out_val    = $signed(rd_val[VAL_W-1:0]);
                        n_out_fid    = rd_val[VAL_W+FID_W-1:VAL_W];
                        n_out_last   = pop_last;
                        n_rptr[r_idx] = (r_rptr[r_idx] == PTR_LAST) ? '0 :
                                        r_rptr[r_idx] + PW'(1);
                        n_fill[r_idx] = r_fill[r_idx] - FW'(1);
                        n_emit        = r_emit + CW'(1);
                    end
                    if ((pop_go && pop_last) || r_idx == IDX_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + SW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_p1_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_emit      <= '0;
            r_idx       <= '0;
            for (int s = 0; s < NUM_SERIES; s++) begin
                r_rptr[s] <= '0;
                r_wptr[s] <= '0;
                r_fill[s] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_p1_vld    <= n_p1_vld;
            r_found     <= n_found;
            r_cnt       <= n_cnt;
            r_emit      <= n_emit;
            r_idx       <= n_idx;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_occ     <= n_p1_occ;
        r_best       <= n_best;
        r_series     <= n_series;
        r_key        <= n_key;
        r_val        <= n_val;
        r_fid        <= n_fid;
        r_out_status <= n_out_status;
        r_out_key    <= n_out_key;
        r_out_series <= n_out_series;
        r_out_val    <= n_out_val;
        r_out_fid    <= n_out_fid;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_merged_key      = r_out_key;
    assign o_source_series   = r_out_series;
    assign o_merged_value    = r_out_val;
    assign o_merged_fidelity = r_out_fid;
    assign o_last            = r_out_last;

`ifndef SYNTHESIS
    // pop pass never emits more entries than the scan counted
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_emit < r_cnt))
        else $error("pop pass ran past counted matches");

    // a pop only comes from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_go |-> (r_fill[r_idx] != '0))
        else $error("pop from empty queue");

    // final pop of a group returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_go && pop_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not finish after last pop");
`endif

endmodule
`default_nettype wire

FILE: bench/sorted_stream_key_merge_tb.sv
// Self-checking testbench for the sorted stream key merge: directed and random transactions.
`timescale 1ns / 100ps
module sorted_stream_key_merge_tb;
    import ssm_pkg::*;

    localparam int SERIES = NUM_SERIES_DEF;
    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int AWAIT_DEPTH = 64;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        t_status                 status;
        logic signed [KEY_W-1:0] key;
        logic [SER_W-1:0]        series;
        logic signed [VAL_W-1:0] value;
        logic [FID_W-1:0]        fidelity;
        logic                    last;
    } t_merge_result;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    in_command = CMD_PUSH;
    logic [SER_W-1:0]        in_series = '0;
    logic signed [KEY_W-1:0] in_key = '0;
    logic signed [VAL_W-1:0] in_value = '0;
    logic [FID_W-1:0]        in_fidelity = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              out_status;
    logic signed [KEY_W-1:0] out_key;
    logic [SER_W-1:0]        out_series;
    logic signed [VAL_W-1:0] out_value;
    logic [FID_W-1:0]        out_fidelity;
    logic                    out_last;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;

    // shadow copy of the per-series queues
    logic signed [KEY_W-1:0] held_key   [SERIES][DEPTH];
    logic signed [VAL_W-1:0] held_value [SERIES][DEPTH];
    logic [FID_W-1:0]        held_fid   [SERIES][DEPTH];
    int                      head_ptr   [SERIES];
    int                      tail_ptr   [SERIES];
    int                      held_count [SERIES];

    // expected results in order, as a ring
    t_merge_result awaited_results [AWAIT_DEPTH];
    int            await_wr = 0;
    int            await_rd = 0;

    sorted_stream_key_merge i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_command         (in_command),
        .i_series          (in_series),
        .i_sample_key      (in_key),
        .i_sample_value    (in_value),
        .i_sample_fidelity (in_fidelity),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (out_status),
        .o_merged_key      (out_key),
        .o_source_series   (out_series),
        .o_merged_value    (out_value),
        .o_merged_fidelity (out_fidelity),
        .o_last            (out_last)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL sorted_stream_key_merge");
        $finish;
    end

    function automatic void queue_result(t_merge_result r);
        awaited_results[await_wr % AWAIT_DEPTH] = r;
        await_wr++;
    endfunction

    // Expected results of one accepted transaction.
    function automatic void merge_predict(t_cmd cmd, logic [SER_W-1:0] ser,
                                          logic signed [KEY_W-1:0] key,
                                          logic signed [VAL_W-1:0] value,
                                          logic [FID_W-1:0] fid);
        t_merge_result           r;
        logic signed [KEY_W-1:0] best;
        logic                    found;
        int                      n_match;
        int                      n_done;
        r = '0;
        r.last = 1'b1;
        if (cmd == CMD_PUSH) begin
            if (ser >= SERIES || held_count[ser] >= DEPTH) begin
                r.status = ST_PUSH_FULL;
            end else begin
                held_key[ser][tail_ptr[ser]]   = key;
                held_value[ser][tail_ptr[ser]] = value;
                held_fid[ser][tail_ptr[ser]]   = fid;
                tail_ptr[ser] = (tail_ptr[ser] + 1) % DEPTH;
                held_count[ser]++;
                r.status = ST_PUSH_OK;
            end
            queue_result(r);
            return;
        end
        found = 1'b0;
        best = '0;
        for (int s = 0; s < SERIES; s++) begin
            if (held_count[s] != 0 && (!found || held_key[s][head_ptr[s]] < best)) begin
                best = held_key[s][head_ptr[s]];
                found = 1'b1;
            end
        end
        if (!found) begin
            r.status = ST_NONE;
            queue_result(r);
            return;
        end
        n_match = 0;
        for (int s = 0; s < SERIES; s++) begin
            if (held_count[s] != 0 && held_key[s][head_ptr[s]] == best && n_match < MAX_OUT)
                n_match++;
        end
        n_done = 0;
        for (int s = 0; s < SERIES; s++) begin
            if (n_done < n_match && held_count[s] != 0 && held_key[s][head_ptr[s]] == best) begin
                r.status   = ST_MERGED;
                r.key      = best;
                r.series   = SER_W'(s);
                r.value    = held_value[s][head_ptr[s]];
                r.fidelity = held_fid[s][head_ptr[s]];
                r.last     = (n_done == n_match - 1);
                queue_result(r);
                head_ptr[s] = (head_ptr[s] + 1) % DEPTH;
                held_count[s]--;
                n_done++;
            end
        end
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            error_count++;
        end
    endfunction

    // Result side: random stalls, every accepted transaction checked in order.
    initial begin : result_monitor
        t_merge_result want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid === 1'b1 && out_ready) begin
                if (await_rd == await_wr) begin
                    $display("%0t: unexpected result: expected none, got status %h key %h",
                             $time, out_status, out_key);
                    error_count++;
                end else begin
                    want = awaited_results[await_rd % AWAIT_DEPTH];
                    await_rd++;
                    check_field("status", 32'(want.status), 32'(out_status));
                    check_field("merged_key", want.key, out_key);
                    check_field("source_series", 32'(want.series), 32'(out_series));
                    check_field("merged_value", want.value, out_value);
                    check_field("merged_fidelity", 32'(want.fidelity), 32'(out_fidelity));
                    check_field("last", 32'(want.last), 32'(out_last));
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Valid is left high on return so back-to-back transactions keep it asserted.
    task automatic send_item(t_cmd cmd, logic [SER_W-1:0] ser, logic signed [KEY_W-1:0] key,
                             logic signed [VAL_W-1:0] value, logic [FID_W-1:0] fid);
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid    <= 1'b1;
        in_command  <= cmd;
        in_series   <= ser;
        in_key      <= key;
        in_value    <= value;
        in_fidelity <= fid;
        do @(posedge clk); while (in_ready !== 1'b1);
        merge_predict(cmd, ser, key, value, fid);
    endtask

    task automatic wait_idle(int tail_cycles);
        in_valid <= 1'b0;
        while (await_rd != await_wr) @(posedge clk);
        repeat (tail_cycles) @(posedge clk);
    endtask

    // Signed extremes of key and value, all fidelity tags, empty merge before and after.
    task automatic test_key_extremes();
        send_item(CMD_NEXT, 2'd0, '0, '0, 2'd0);
        send_item(CMD_PUSH, 2'd0, KEY_MAX, VAL_MIN, 2'd0);
        send_item(CMD_PUSH, 2'd1, KEY_MIN, VAL_MAX, 2'd3);
        send_item(CMD_PUSH, 2'd2, 32'sd0, -32'sd1, 2'd1);
        send_item(CMD_PUSH, 2'd3, -32'sd1, 32'sd0, 2'd2);
        repeat (5) send_item(CMD_NEXT, 2'd3, KEY_MAX, VAL_MAX, 2'd3);
        wait_idle(20);
    endtask

    // Ties across series pop together in series order; larger heads stay queued.
    task automatic test_equal_heads();
        for (int s = 0; s < SERIES; s++)
            send_item(CMD_PUSH, SER_W'(s), 32'sh0001_8000, 32'sh0010_0000 * (s + 1),
                      FID_W'(s));
        send_item(CMD_NEXT, 2'd0, '0, '0, 2'd0);
        send_item(CMD_PUSH, 2'd1, -32'sh0000_4000, 32'sh1234_5678, 2'd2);
        send_item(CMD_PUSH, 2'd3, -32'sh0000_4000, -32'sh1234_5678, 2'd1);
        send_item(CMD_PUSH, 2'd0, 32'sh0000_0005, 32'sh7654_3210, 2'd3);
        send_item(CMD_NEXT, 2'd0, '0, '0, 2'd0);
        send_item(CMD_NEXT, 2'd0, '0, '0, 2'd0);
        wait_idle(20);
    endtask

    // Out-of-order keys in one series: only heads compared, first ready series not series 0.
    task automatic test_unsorted_series();
        send_item(CMD_PUSH, 2'd3, 32'sd5, 32'sd50, 2'd1);
        send_item(CMD_PUSH, 2'd3, 32'sd2, 32'sd20, 2'd2);
        send_item(CMD_PUSH, 2'd2, 32'sd7, 32'sd70, 2'd3);
        repeat (3) send_item(CMD_NEXT, 2'd1, '0, '0, 2'd0);
        wait_idle(20);
    endtask

    // Fill one queue, get a reject, pop once, wrap the write pointer, reject again.
    task automatic test_full_queue();
        for (int i = 0; i < DEPTH; i++)
            send_item(CMD_PUSH, 2'd2, 32'sd100 + i, $urandom, FID_W'($urandom_range(3)));
        send_item(CMD_PUSH, 2'd2, 32'sd200, $urandom, FID_W'($urandom_range(3)));
        send_item(CMD_NEXT, 2'd2, '0, '0, 2'd0);
        send_item(CMD_PUSH, 2'd2, 32'sd201, $urandom, FID_W'($urandom_range(3)));
        send_item(CMD_PUSH, 2'd2, 32'sd202, $urandom, FID_W'($urandom_range(3)));
        wait_idle(20);
    endtask

    // Mostly sorted pushes on a shared key clock so heads tie often, some random-key noise.
    task automatic test_random_merge(int n_items, int idle_pct, int stall_pct);
        logic signed [KEY_W-1:0] base_key;
        logic signed [KEY_W-1:0] key;
        int                      tick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        base_key = $urandom;
        tick = 0;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(99) < 55) begin
                tick += ($urandom_range(2) == 0);
                key = ($urandom_range(9) == 0) ? $urandom : base_key + tick;
                send_item(CMD_PUSH, SER_W'($urandom_range(SERIES - 1)), key, $urandom,
                          FID_W'($urandom_range(3)));
            end else begin
                send_item(CMD_NEXT, SER_W'($urandom_range(SERIES - 1)), $urandom, $urandom,
                          FID_W'($urandom_range(3)));
            end
        end
        wait_idle(20);
    endtask

    initial begin
        for (int s = 0; s < SERIES; s++) begin
            head_ptr[s]   = 0;
            tail_ptr[s]   = 0;
            held_count[s] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_key_extremes();
        test_equal_heads();
        test_unsorted_series();
        test_full_queue();
        test_random_merge(18, 0, 0);
        test_random_merge(18, 65, 0);
        test_random_merge(18, 0, 65);
        test_random_merge(10, 7, 7);
        wait_idle(40);
        if (error_count == 0)
            $display("PASS sorted_stream_key_merge");
        else
            $display("FAIL sorted_stream_key_merge");
        $finish;
    end

endmodule
